@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/e2c_pkg.sv @@
// Shared types, constants and helper functions for the epoch-to-calendar block.
package e2c_pkg;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam int unsigned EPOCH_WEEKDAY = 4;
    localparam int unsigned DAYS_PER_WEEK = 7;

    localparam int unsigned ZONE_W   = 17;
    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned TIME_W   = 33;
    localparam int unsigned ADJ_W    = 34;
    localparam int unsigned DAYS_W   = 17;
    localparam int unsigned SOD_W    = 17;
    localparam int unsigned MOD_W    = 11;

    // Split by reciprocal multiply after dropping the power-of-two factor:
    // days = (t >> 7) / 675, minutes = (sod >> 2) / 15, hours = (mod >> 2) / 15.
    localparam int unsigned DAY_PRE    = 7;
    localparam int unsigned DAY_X_W    = 26;
    localparam int unsigned DAY_M_W    = 27;
    localparam int unsigned DAY_P_W    = 53;
    localparam int unsigned DAY_SHIFT  = 36;
    localparam logic [26:0] DAY_RECIP  = 27'd101806633;

    localparam int unsigned MIN_PRE    = 2;
    localparam int unsigned MIN_X_W    = 15;
    localparam int unsigned MIN_M_W    = 16;
    localparam int unsigned MIN_P_W    = 31;
    localparam int unsigned MIN_SHIFT  = 19;
    localparam logic [15:0] MIN_RECIP  = 16'd34953;

    localparam int unsigned HOUR_PRE   = 2;
    localparam int unsigned HOUR_X_W   = 9;
    localparam int unsigned HOUR_M_W   = 10;
    localparam int unsigned HOUR_P_W   = 19;
    localparam int unsigned HOUR_SHIFT = 13;
    localparam logic [9:0]  HOUR_RECIP = 10'd547;

    localparam logic [3:0] LAST_MONTH = 4'd11;
    localparam logic [3:0] MON_FEB    = 4'd1;

    localparam logic CFG_ZONE = 1'b0;
    localparam logic CFG_DST  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_SOD,
        ST_MINS,
        ST_HOURS,
        ST_YEAR,
        ST_MONTH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic split_day;
        logic split_sod;
        logic split_min;
        logic split_hour;
        logic year_step;
        logic month_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
    } t_status;

    // Fold 3-bit digits, since 8 is 1 modulo 7.
    function automatic logic [2:0] mod7(input logic [DAYS_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
             + 6'(x[14:12]) + 6'(x[16:15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        if (s2 >= 4'(DAYS_PER_WEEK)) begin
            s2 = s2 - 4'(DAYS_PER_WEEK);
        end
        return s2[2:0];
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] ml;
        case (mon) inside
            MON_FEB:                  ml = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  ml = 5'd30;
            default:                  ml = 5'd31;
        endcase
        return ml;
    endfunction

endpackage

@@ rtl/e2c_ctrl.sv @@
// Sequencer for the epoch-to-calendar block: handshakes and datapath commands.
module e2c_ctrl import e2c_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DAYS;
            end
            ST_DAYS:  n_state = ST_SOD;
            ST_SOD:   n_state = ST_MINS;
            ST_MINS:  n_state = ST_HOURS;
            ST_HOURS: n_state = ST_YEAR;
            ST_YEAR: begin
                if (!i_status.year_fits) n_state = ST_MONTH;
            end
            ST_MONTH: begin
                if (!i_status.month_fits) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            ST_DAYS: begin
                o_cmd.split_day = 1'b1;
            end
            ST_SOD: begin
                o_cmd.split_sod = 1'b1;
            end
            ST_MINS: begin
                o_cmd.split_min = 1'b1;
            end
            ST_HOURS: begin
                o_cmd.split_hour = 1'b1;
            end
            ST_YEAR: begin
                o_cmd.year_step = 1'b1;
            end
            ST_MONTH: begin
                o_cmd.month_step = 1'b1;
            end
            ST_OUT: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/e2c_dp.sv @@
// Datapath: zone adjust, reciprocal-multiply splitters, year and month steppers, result word.
module e2c_dp import e2c_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [ZONE_W-1:0]     i_cfg_data,
    input  logic [EPOCH_W-1:0]    i_epoch_seconds,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [11:0]           o_year,
    output logic [3:0]            o_month,
    output logic [4:0]            o_day_of_month,
    output logic [4:0]            o_hour,
    output logic [5:0]            o_minute,
    output logic [5:0]            o_second,
    output logic [2:0]            o_weekday,
    output logic [8:0]            o_day_of_year,
    output logic                  o_dst_out,
    output logic                  o_before_epoch
);

    logic [ZONE_W-1:0] r_zone;
    logic              r_dst;

    logic [TIME_W-1:0] r_t;
    logic              r_neg;
    logic              r_dst_item;
    logic [DAYS_W-1:0] r_days;
    logic [SOD_W-1:0]  r_sod;
    logic [MOD_W-1:0]  r_mod;
    logic [4:0]        r_hour;
    logic [5:0]        r_second;
    logic [2:0]        r_wday;
    logic [11:0]       r_year;
    logic [6:0]        r_c100;
    logic [8:0]        r_c400;
    logic [3:0]        r_mon;
    logic [8:0]        r_mday;

    logic [ADJ_W-1:0]    adj;
    logic [ADJ_W-1:0]    dst_add;
    logic [DAY_P_W-1:0]  day_prod;
    logic [TIME_W-1:0]   day_base;
    logic [TIME_W-1:0]   sod;
    logic [MIN_P_W-1:0]  min_prod;
    logic [SOD_W-1:0]    min_base;
    logic [SOD_W-1:0]    sec_left;
    logic [HOUR_P_W-1:0] hour_prod;
    logic [MOD_W-1:0]    hour_base;
    logic [MOD_W-1:0]    min_left;
    logic                leap;
    logic [8:0]          ylen;
    logic [4:0]          ml;

    assign dst_add = r_dst ? ADJ_W'(SECS_PER_HOUR) : '0;
    assign adj     = {2'b00, i_epoch_seconds} - {{(ADJ_W-ZONE_W){r_zone[ZONE_W-1]}}, r_zone}
                     + dst_add;

    assign day_prod  = {{DAY_M_W{1'b0}}, r_t[TIME_W-1:DAY_PRE]} * {{DAY_X_W{1'b0}}, DAY_RECIP};
    assign day_base  = {{(TIME_W-DAYS_W){1'b0}}, r_days} * TIME_W'(SECS_PER_DAY);
    assign sod       = r_t - day_base;
    assign min_prod  = {{MIN_M_W{1'b0}}, r_sod[SOD_W-1:MIN_PRE]} * {{MIN_X_W{1'b0}}, MIN_RECIP};
    assign min_base  = {{(SOD_W-MOD_W){1'b0}}, r_mod} * SOD_W'(SECS_PER_MIN);
    assign sec_left  = r_sod - min_base;
    assign hour_prod = {{HOUR_M_W{1'b0}}, r_mod[MOD_W-1:HOUR_PRE]}
                       * {{HOUR_X_W{1'b0}}, HOUR_RECIP};
    assign hour_base = {{(MOD_W-5){1'b0}}, r_hour} * MOD_W'(SECS_PER_MIN);
    assign min_left  = r_mod - hour_base;

    assign leap = ((r_year[1:0] == 2'b00) && (r_c100 != '0)) || (r_c400 == '0);
    assign ylen = 9'(DAYS_PER_YEAR) + {8'd0, leap};
    assign ml   = month_len(r_mon, leap);

    assign o_status.year_fits  = (r_days >= {8'd0, ylen});
    assign o_status.month_fits = (r_mon != LAST_MONTH) && (r_mday >= {4'd0, ml});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
            r_dst  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ZONE: r_zone <= i_cfg_data;
                CFG_DST:  r_dst  <= i_cfg_data[0];
                default:  r_dst  <= r_dst;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t        <= adj[ADJ_W-1] ? '0 : adj[TIME_W-1:0];
            r_neg      <= adj[ADJ_W-1];
            r_dst_item <= r_dst;
            r_year     <= 12'(EPOCH_YEAR);
            r_c100     <= 7'(EPOCH_YEAR % 100);
            r_c400     <= 9'(EPOCH_YEAR % 400);
        end

        if (i_cmd.split_day) begin
            r_days <= day_prod[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
        end

        if (i_cmd.split_sod) begin
            r_sod  <= sod[SOD_W-1:0];
            r_wday <= mod7(r_days + DAYS_W'(EPOCH_WEEKDAY));
        end

        if (i_cmd.split_min) begin
            r_mod <= min_prod[MIN_SHIFT+MOD_W-1:MIN_SHIFT];
        end

        if (i_cmd.split_hour) begin
            r_hour   <= hour_prod[HOUR_SHIFT+4:HOUR_SHIFT];
            r_second <= sec_left[5:0];
        end

        if (i_cmd.year_step) begin
            if (o_status.year_fits) begin
                r_days <= r_days - {8'd0, ylen};
                r_year <= r_year + 1'b1;
                r_c100 <= (r_c100 == 7'd99) ? '0 : r_c100 + 1'b1;
                r_c400 <= (r_c400 == 9'd399) ? '0 : r_c400 + 1'b1;
            end else begin
                r_mday <= r_days[8:0];
                r_mon  <= '0;
            end
        end

        if (i_cmd.month_step && o_status.month_fits) begin
            r_mday <= r_mday - {4'd0, ml};
            r_mon  <= r_mon + 1'b1;
        end

        if (i_cmd.out_load) begin
            o_year         <= r_year;
            o_month        <= r_mon + 1'b1;
            o_day_of_month <= r_mday[4:0] + 1'b1;
            o_hour         <= r_hour;
            o_minute       <= min_left[5:0];
            o_second       <= r_second;
            o_weekday      <= r_wday;
            o_day_of_year  <= r_days[8:0];
            o_dst_out      <= r_dst_item;
            o_before_epoch <= r_neg;
        end
    end

endmodule

@@ rtl/epoch_seconds_to_calendar.sv @@
// Top level of the epoch-seconds to calendar date and time converter.
// Converts one 32-bit Unix time word at a time into local civil date and time. The
// word is zone-adjusted in the accept cycle, then four steps split it by
// reciprocal multiplication into days, seconds of day, minutes of day and hours, and a
// stepper walks one calendar year per cycle and then one month per cycle. The next
// input word is taken from the cycle after the result has moved into the output
// register, which then holds it until the consumer takes it; while that register is
// still full, the finished result waits and the input stays stalled.
`include "assert_macros.svh"

module epoch_seconds_to_calendar import e2c_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [ZONE_W-1:0]     i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [EPOCH_W-1:0]    i_epoch_seconds,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [11:0]           o_year,
    output logic [3:0]            o_month,
    output logic [4:0]            o_day_of_month,
    output logic [4:0]            o_hour,
    output logic [5:0]            o_minute,
    output logic [5:0]            o_second,
    output logic [2:0]            o_weekday,
    output logic [8:0]            o_day_of_year,
    output logic                  o_dst_out,
    output logic                  o_before_epoch
);

    t_cmd    cmd;
    t_status status;
    logic    time_ok;
    logic    clamp_ok;

    e2c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    e2c_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_epoch_seconds (i_epoch_seconds),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday),
        .o_day_of_year   (o_day_of_year),
        .o_dst_out       (o_dst_out),
        .o_before_epoch  (o_before_epoch)
    );

    assign time_ok  = (o_hour < 5'd24) && (o_minute < 6'd60) && (o_second < 6'd60)
                      && (o_weekday < 3'd7);
    assign clamp_ok = (o_year == 12'd1970) && (o_day_of_year == 9'd0) && (o_hour == 5'd0);

    `ASSERT_NEXT(a_accept_starts_days, i_clk, i_rst_n, i_in_valid && !o_in_stall, cmd.split_day)
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, cmd.out_load, !(o_out_valid && i_out_stall))
    `ASSERT_IMPLY(a_time_in_range, i_clk, i_rst_n, o_out_valid, time_ok)
    `ASSERT_IMPLY(a_clamp_is_epoch, i_clk, i_rst_n, o_out_valid && o_before_epoch, clamp_ok)

endmodule

@@ tb/calendar_sb_pkg.sv @@
// Scoreboard for the epoch-seconds to calendar converter: conversion predictor and result check.
package calendar_sb_pkg;

    import e2c_pkg::*;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  wday;
        logic [8:0]  yday;
        logic        dst;
        logic        before_epoch;
    } calendar_t;

    class calendar_scoreboard;
        bit signed [ZONE_W-1:0] zone_offset;
        bit                     dst_on;
        calendar_t              calendar_q[$];
        int unsigned            words_in;
        int unsigned            words_checked;
        int unsigned            mismatches;
        int unsigned            orphans;
        int unsigned            reports;

        function new();
            zone_offset   = '0;
            dst_on        = 1'b0;
            words_in      = 0;
            words_checked = 0;
            mismatches    = 0;
            orphans       = 0;
            reports       = 0;
        endfunction

        function void set_zone(bit [ZONE_W-1:0] value);
            zone_offset = value;
        endfunction

        function void set_dst(bit [ZONE_W-1:0] value);
            dst_on = value[0];
        endfunction

        function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function calendar_t to_calendar(bit [EPOCH_W-1:0] epoch);
            int unsigned       month_days [12];
            longint            adj;
            longint unsigned   t;
            longint unsigned   days;
            longint unsigned   secs;
            int unsigned       year;
            int unsigned       mon;
            int unsigned       rem_days;
            int unsigned       mlen;
            calendar_t         r;
            month_days = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            adj = longint'(epoch) - longint'(zone_offset) + (dst_on ? 3600 : 0);
            r.before_epoch = (adj < 0);
            if (adj < 0) begin
                adj = 0;
            end
            t    = adj;
            days = t / 86400;
            secs = t % 86400;
            year = 1970;
            while (days >= 365 + leap_year(year)) begin
                days -= 365 + leap_year(year);
                year++;
            end
            r.yday   = days;
            rem_days = days;
            mon      = 0;
            while (mon < 11) begin
                mlen = month_days[mon] + ((mon == 1) ? leap_year(year) : 0);
                if (rem_days < mlen) begin
                    break;
                end
                rem_days -= mlen;
                mon++;
            end
            r.year   = year;
            r.month  = mon + 1;
            r.mday   = rem_days + 1;
            r.hour   = secs / 3600;
            r.minute = (secs % 3600) / 60;
            r.second = secs % 60;
            r.wday   = (t / 86400 + 4) % 7;
            r.dst    = dst_on;
            return r;
        endfunction

        function void note_word(bit [EPOCH_W-1:0] epoch);
            calendar_q.push_back(to_calendar(epoch));
            words_in++;
        endfunction

        function void check_word(calendar_t got);
            calendar_t want;
            string     diffs;
            if (calendar_q.size() == 0) begin
                orphans++;
                reports++;
                if (reports <= 10) begin
                    $display("unexpected result word %0d-%0d-%0d %0d:%0d:%0d",
                             got.year, got.month, got.mday, got.hour, got.minute, got.second);
                end
                return;
            end
            want = calendar_q.pop_front();
            words_checked++;
            diffs = "";
            if (got.year !== want.year) diffs = {diffs, " year"};
            if (got.month !== want.month) diffs = {diffs, " month"};
            if (got.mday !== want.mday) diffs = {diffs, " day_of_month"};
            if (got.hour !== want.hour) diffs = {diffs, " hour"};
            if (got.minute !== want.minute) diffs = {diffs, " minute"};
            if (got.second !== want.second) diffs = {diffs, " second"};
            if (got.wday !== want.wday) diffs = {diffs, " weekday"};
            if (got.yday !== want.yday) diffs = {diffs, " day_of_year"};
            if (got.dst !== want.dst) diffs = {diffs, " dst_out"};
            if (got.before_epoch !== want.before_epoch) diffs = {diffs, " before_epoch"};
            if (diffs != "") begin
                mismatches++;
                reports++;
                if (reports <= 10) begin
                    $display("word %0d wrong:%s", words_checked, diffs);
                    $display("  exp %0d-%0d-%0d %0d:%0d:%0d wd %0d yd %0d dst %0d neg %0d",
                             want.year, want.month, want.mday, want.hour, want.minute,
                             want.second, want.wday, want.yday, want.dst, want.before_epoch);
                    $display("  got %0d-%0d-%0d %0d:%0d:%0d wd %0d yd %0d dst %0d neg %0d",
                             got.year, got.month, got.mday, got.hour, got.minute,
                             got.second, got.wday, got.yday, got.dst, got.before_epoch);
                end
            end
        endfunction

        function int unsigned pending();
            return calendar_q.size();
        endfunction

        function bit failed();
            return (mismatches != 0) || (orphans != 0) || (calendar_q.size() != 0);
        endfunction
    endclass

endpackage

@@ tb/tb_epoch_seconds_to_calendar.sv @@
// Testbench top for the epoch-seconds to calendar converter with random flow control.
module tb_epoch_seconds_to_calendar;

    timeunit 1ns;
    timeprecision 1ps;

    import e2c_pkg::*;
    import calendar_sb_pkg::*;

    localparam int unsigned IDLE_LIMIT      = 5000;
    localparam int unsigned HOLD_CYCLES     = 600;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned WORDS_PER_PHASE = 72;
    localparam int unsigned TAIL_CYCLES     = 200;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [ZONE_W-1:0]   i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [EPOCH_W-1:0]  i_epoch_seconds;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [11:0]         o_year;
    logic [3:0]          o_month;
    logic [4:0]          o_day_of_month;
    logic [4:0]          o_hour;
    logic [5:0]          o_minute;
    logic [5:0]          o_second;
    logic [2:0]          o_weekday;
    logic [8:0]          o_day_of_year;
    logic                o_dst_out;
    logic                o_before_epoch;

    calendar_scoreboard  sb;
    bit                  tx_idle_on    = 1'b0;
    bit                  rx_random     = 1'b0;
    bit                  hold_request  = 1'b0;
    int unsigned         rx_hold_left  = 0;
    int unsigned         idle_cycles   = 0;
    int unsigned         config_phases = 0;
    logic [EPOCH_W-1:0]  year_edges [11];

    epoch_seconds_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second),
        .o_weekday       (o_weekday),
        .o_day_of_year   (o_day_of_year),
        .o_dst_out       (o_dst_out),
        .o_before_epoch  (o_before_epoch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(15, 4);
        return $urandom_range(120, 30);
    endfunction

    function automatic logic [EPOCH_W-1:0] random_word();
        int unsigned r;
        longint      edge_word;
        r = $urandom_range(99);
        if (r < 55) return $urandom;
        if (r < 70) return $urandom_range(200000);
        if (r < 85) begin
            edge_word = longint'(year_edges[$urandom_range(10)]) + $urandom_range(200000)
                        - 100000;
            return edge_word[EPOCH_W-1:0];
        end
        return $urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000);
    endfunction

    function automatic logic [ZONE_W-1:0] random_zone();
        int unsigned r;
        int          z;
        r = $urandom_range(99);
        if (r < 15) return 17'h10000;
        if (r < 30) return 17'h0FFFF;
        if (r < 38) return 17'(50400);
        if (r < 46) return 17'(-50400);
        z = $urandom_range(100800) - 50400;
        return 17'(z);
    endfunction

    // receiver: random stall, or a long hold on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            i_out_stall <= 1'b1;
            rx_hold_left--;
        end else if (rx_random && $urandom_range(99) < 30) begin
            i_out_stall <= 1'b1;
            rx_hold_left = pick_gap();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_word(i_epoch_seconds);
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_word({o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                               o_weekday, o_day_of_year, o_dst_out, o_before_epoch});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("tb_epoch_seconds_to_calendar: FAIL");
            $finish;
        end
    end

    task automatic send_word(input logic [EPOCH_W-1:0] epoch);
        int unsigned gap;
        gap = tx_idle_on ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid      <= 1'b0;
            i_epoch_seconds <= $urandom;
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_epoch_seconds <= epoch;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ZONE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_ZONE) begin
            sb.set_zone(value);
        end else begin
            sb.set_dst(value);
        end
    endtask

    task automatic set_config(input logic [ZONE_W-1:0] zone, input logic dst);
        logic [ZONE_W-1:0] dst_word;
        dst_word    = $urandom;
        dst_word[0] = dst;
        drain();
        write_reg(CFG_ZONE, zone);
        write_reg(CFG_DST, dst_word);
        config_phases++;
    endtask

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_ZONE;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_epoch_seconds = '0;
        i_out_stall     = 1'b0;
        year_edges = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd68255999,
                       32'd94694399, 32'd951782400, 32'd946684799, 32'd4107542399,
                       32'd4107542400, 32'd4260211199};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: calendar edges, leap days, non-leap century
        tx_idle_on = 1'b1;
        rx_random  = 1'b1;
        foreach (year_edges[k]) send_word(year_edges[k]);

        // clamp below the epoch and the first unclamped second, the epoch itself
        set_config(17'(18000), 1'b1);
        send_word(32'd0);
        send_word(32'd14399);
        send_word(32'd14400);

        // most negative offset with dst reaches the last representable date
        set_config(17'h10000, 1'b1);
        send_word(32'hFFFF_FFFF);
        send_word(32'd0);

        set_config(17'h0FFFF, 1'b0);
        send_word(32'd65534);
        send_word(32'd65535);
        send_word(32'd65536);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config(random_zone(), $urandom_range(1));
            tx_idle_on = (p != 2);
            rx_random  = (p != 2);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (p == 3 && i == 10) begin
                    hold_request = 1'b1;
                end
                if (p == 4 && i == WORDS_PER_PHASE / 2) begin
                    drain();
                end
                send_word(random_word());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("converted %0d words over %0d register settings, %0d results checked",
                 sb.words_in, config_phases, sb.words_checked);
        $display("offsets spanned both 17-bit extremes with dst on and off, under long output holds");
        if (!sb.failed()) begin
            $display("tb_epoch_seconds_to_calendar: PASS");
        end else begin
            $display("%0d wrong, %0d unexpected, %0d missing results",
                     sb.mismatches, sb.orphans, sb.pending());
            $display("tb_epoch_seconds_to_calendar: FAIL");
        end
        $finish;
    end

endmodule
